@@ hdl/swst_pkg.sv @@
// Package for the sliding window send tracker: command and result structs,
// function and result codes, window constants, FSM state type.
// No dependencies.
package swst_pkg;

  // Window slots; slot index is the low bits of the sequence number.
  localparam int unsigned WINDOW_SLOTS = 64;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int unsigned INFL_W       = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned MSS_BYTES    = 1460;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  // Command codes
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_SCAN = 2'd2;

  // Result codes
  localparam logic [2:0] KIND_GRANT     = 3'd0;
  localparam logic [2:0] KIND_REFUSE    = 3'd1;
  localparam logic [2:0] KIND_ACK_TAKEN = 3'd2;
  localparam logic [2:0] KIND_ACK_IGNOR = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd4;
  localparam logic [2:0] KIND_NONE_EXP  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] now_time;
    logic [31:0] ack_seq;
    logic [31:0] remaining_bytes;
    logic [31:0] cong_window;
  } swst_cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [31:0]       seq_out;
    logic [15:0]       chunk_len;
    logic [SLOT_W-1:0] slot_index;
    logic [63:0]       age_us;
    logic              is_dup;
    logic [15:0]       dup_count;
    logic [INFL_W-1:0] inflight;
    logic              last;
  } swst_res_t;

  // One slot record as stored in the slot memory.
  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] send_time;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK,
    ST_SCAN,
    ST_FLUSH
  } swst_state_e;

endpackage

@@ hdl/swst_slot_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the per-slot sequence and send time records. No dependencies.
module swst_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/swst_ctrl.sv @@
// Control of the send tracker: command FSM, slot valid bits, window counters,
// slot memory write and read, and the timeout scan. Uses swst_pkg, swst_slot_ram.
module swst_ctrl
  import swst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  swst_cmd_t   cmd_i,
  input  logic [31:0] timeout_i,
  output logic        busy_o,
  output logic        res_load_o,
  output swst_res_t   res_o
);

  swst_state_e state_q, state_d;
  swst_cmd_t   op_q, op_d;
  logic [SLOT_W-1:0] scan_idx_q, scan_idx_d;
  swst_res_t   pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;
  logic [WINDOW_SLOTS-1:0] in_use_q, in_use_d;
  logic [31:0] next_seq_q, next_seq_d;
  logic [31:0] last_acked_q, last_acked_d;
  logic [15:0] dup_cnt_q, dup_cnt_d;
  logic [INFL_W-1:0] inflight_q, inflight_d;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_raddr;
  slot_rec_t         mem_wdata;
  slot_rec_t         mem_rdata;

  logic [SLOT_W-1:0] send_idx;
  logic [SLOT_W-1:0] ack_idx;
  logic [63:0]       age;
  logic [31:0]       win_need;
  logic              win_ok;
  logic              grant;
  logic              ack_hit;
  logic              expired;
  swst_res_t         res_d;

  swst_slot_ram #(
    .DEPTH (WINDOW_SLOTS),
    .WIDTH ($bits(slot_rec_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (send_idx),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign send_idx = next_seq_q[SLOT_W-1:0];
  assign ack_idx  = op_q.ack_seq[SLOT_W-1:0];
  assign age      = op_q.now_time - mem_rdata.send_time;

  // inflight < max(1, cwnd / MSS)  <=>  inflight == 0 || (inflight + 1) * MSS <= cwnd
  assign win_need = (32'(inflight_q) + 32'd1) * 32'(MSS_BYTES);
  assign win_ok   = (inflight_q == '0) || (win_need <= op_q.cong_window);
  assign grant    = (op_q.remaining_bytes != 32'd0) && win_ok && !in_use_q[send_idx];
  assign ack_hit  = in_use_q[ack_idx] && (mem_rdata.seq == op_q.ack_seq);
  assign expired  = in_use_q[scan_idx_q] && (age > {32'd0, timeout_i});

  assign mem_wdata.seq       = next_seq_q;
  assign mem_wdata.send_time = op_q.now_time;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    scan_idx_d   = scan_idx_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    in_use_d     = in_use_q;
    next_seq_d   = next_seq_q;
    last_acked_d = last_acked_q;
    dup_cnt_d    = dup_cnt_q;
    inflight_d   = inflight_q;
    mem_we       = 1'b0;
    mem_raddr    = '0;
    res_d        = '0;
    res_load_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d = cmd_i;
          unique case (cmd_i.func)
            FUNC_SEND: state_d = ST_SEND;
            FUNC_ACK: begin
              state_d   = ST_ACK;
              mem_raddr = cmd_i.ack_seq[SLOT_W-1:0];
            end
            FUNC_SCAN: begin
              state_d    = ST_SCAN;
              scan_idx_d = '0;
              pend_vld_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_SEND: begin
        res_load_o      = 1'b1;
        res_d.last      = 1'b1;
        res_d.dup_count = dup_cnt_q;
        if (grant) begin
          mem_we            = 1'b1;
          in_use_d[send_idx] = 1'b1;
          next_seq_d        = next_seq_q + 32'd1;
          inflight_d        = inflight_q + INFL_W'(1);
          res_d.kind        = KIND_GRANT;
          res_d.seq_out     = next_seq_q;
          res_d.slot_index  = send_idx;
          res_d.chunk_len   = (op_q.remaining_bytes < 32'(MSS_BYTES)) ?
                              op_q.remaining_bytes[15:0] : 16'(MSS_BYTES);
          res_d.inflight    = inflight_q + INFL_W'(1);
        end else begin
          res_d.kind     = KIND_REFUSE;
          res_d.seq_out  = next_seq_q;
          res_d.inflight = inflight_q;
        end
        state_d = ST_IDLE;
      end

      ST_ACK: begin
        res_load_o       = 1'b1;
        res_d.last       = 1'b1;
        res_d.seq_out    = op_q.ack_seq;
        res_d.slot_index = ack_idx;
        res_d.dup_count  = dup_cnt_q;
        res_d.inflight   = inflight_q;
        res_d.kind       = KIND_ACK_IGNOR;
        if (ack_hit) begin
          in_use_d[ack_idx] = 1'b0;
          inflight_d        = inflight_q - INFL_W'(1);
          res_d.kind        = KIND_ACK_TAKEN;
          res_d.age_us      = age;
          res_d.inflight    = inflight_q - INFL_W'(1);
          if (op_q.ack_seq == last_acked_q) begin
            res_d.is_dup = 1'b1;
            if (dup_cnt_q != 16'hFFFF) begin
              dup_cnt_d = dup_cnt_q + 16'd1;
            end
            res_d.dup_count = dup_cnt_d;
          end else begin
            dup_cnt_d       = '0;
            last_acked_d    = op_q.ack_seq;
            res_d.dup_count = '0;
          end
        end
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        // Read data for scan_idx_q is valid now; fetch the next slot.
        mem_raddr = scan_idx_q + SLOT_W'(1);
        if (expired) begin
          in_use_d[scan_idx_q] = 1'b0;
          inflight_d           = inflight_q - INFL_W'(1);
          if (pend_vld_q) begin
            res_load_o = 1'b1;
            res_d      = pend_q;
          end
          pend_d            = '0;
          pend_d.kind       = KIND_TIMEOUT;
          pend_d.seq_out    = mem_rdata.seq;
          pend_d.slot_index = scan_idx_q;
          pend_d.age_us     = age;
          pend_d.dup_count  = dup_cnt_q;
          pend_d.inflight   = inflight_q - INFL_W'(1);
          pend_vld_d        = 1'b1;
        end
        if (scan_idx_q == SLOT_W'(WINDOW_SLOTS - 1)) begin
          state_d = ST_FLUSH;
        end else begin
          scan_idx_d = scan_idx_q + SLOT_W'(1);
        end
      end

      ST_FLUSH: begin
        res_load_o = 1'b1;
        if (pend_vld_q) begin
          res_d = pend_q;
        end else begin
          res_d.kind      = KIND_NONE_EXP;
          res_d.dup_count = dup_cnt_q;
          res_d.inflight  = inflight_q;
        end
        res_d.last = 1'b1;
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_vld_q   <= 1'b0;
      in_use_q     <= '0;
      next_seq_q   <= '0;
      last_acked_q <= '0;
      dup_cnt_q    <= '0;
      inflight_q   <= '0;
      scan_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      pend_vld_q   <= pend_vld_d;
      in_use_q     <= in_use_d;
      next_seq_q   <= next_seq_d;
      last_acked_q <= last_acked_d;
      dup_cnt_q    <= dup_cnt_d;
      inflight_q   <= inflight_d;
      scan_idx_q   <= scan_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pend_q <= pend_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_d;

`ifndef NO_ASSERTIONS
  a_inflight_matches_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) == 32'(inflight_q))
    else $error("inflight count out of step with slot valid bits");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i.func == FUNC_SEND || cmd_i.func == FUNC_ACK))
      |=> res_load_o && res_o.last)
    else $error("send or ack did not produce its single result");

  a_pend_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
    else $error("pending timeout held outside a scan");

  a_scan_ends_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_idx_q == SLOT_W'(WINDOW_SLOTS - 1)) |=> state_q == ST_FLUSH)
    else $error("scan did not close with a flush");
`endif

endmodule

@@ hdl/sliding_window_send_tracker_top.sv @@
// Top level of the sliding window send tracker: timeout register, result
// register and the control block. Uses swst_pkg and swst_ctrl.
//
// Usage:
//   Command channel: drive cmd_i and raise start_i; the transaction is taken
//   at a rising edge with start_i high and busy_o low. func selects a send
//   request, an acknowledgement or a timeout scan; an unused func code is
//   taken and dropped without a result.
//   Result channel: each result sits on res_o for exactly one cycle with
//   res_strobe_o high; res_o.last marks the final result of a command. The
//   receiver cannot stall, so capture every strobe.
//   Configuration: timeout_we_i writes timeout_wdata_i into the timeout
//   register at once; write it only while the block is idle.
// Timing:
//   Send and ack: busy_o is high in ST_SEND or ST_ACK after the accepting edge
//   (an ack reads its slot at that edge); the result strobes as busy_o falls.
//   Scan: busy in ST_SCAN over every slot, then ST_FLUSH, one slot memory read
//   per cycle; each timed-out result is held back until the next one or the
//   flush, so the final one can carry last.
//   Reset: all slots empty, counters zero, timeout 1000000 us.
module sliding_window_send_tracker_top
  import swst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  swst_cmd_t   cmd_i,
  output logic        busy_o,
  input  logic        timeout_we_i,
  input  logic [31:0] timeout_wdata_i,
  output logic        res_strobe_o,
  output swst_res_t   res_o
);

  logic [31:0] timeout_q;
  logic        res_strobe_q;
  swst_res_t   res_q;
  logic        res_load;
  swst_res_t   res_d;

  // Hold the timeout threshold; a slot expires when its age exceeds it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (timeout_we_i) begin
      timeout_q <= timeout_wdata_i;
    end
  end

  swst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .timeout_i  (timeout_q),
    .busy_o     (busy_o),
    .res_load_o (res_load),
    .res_o      (res_d)
  );

  // Register each result for one cycle of strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

@@ dv/sliding_window_send_tracker_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_send_tracker_top: a window tracker
// mirror predicts every result; directed and random send, ack and scan traffic drive it.
// Depends on swst_pkg and the tracker RTL.
module sliding_window_send_tracker_top_tb;
  import swst_pkg::*;

  // func code the block takes and drops without a result
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  // idle cycles let pass before a timeout write and at the end; covers a full scan
  localparam int unsigned SETTLE_CYCLES = 100;
  // longest correct quiet stretch is a settle wait, or a drain plus a scan plus a
  // long sender gap, far below this
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned BACKLOG_DEPTH = 2;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  swst_cmd_t   cmd_i           = '0;
  logic        busy_o;
  logic        timeout_we_i    = 1'b0;
  logic [31:0] timeout_wdata_i = '0;
  logic        res_strobe_o;
  swst_res_t   res_o;

  sliding_window_send_tracker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .timeout_we_i   (timeout_we_i),
    .timeout_wdata_i(timeout_wdata_i),
    .res_strobe_o   (res_strobe_o),
    .res_o          (res_o)
  );

  // Mirror of the window state; bit types start at zero like the block after reset.
  bit                win_used   [WINDOW_SLOTS];
  bit                win_written[WINDOW_SLOTS];
  bit [31:0]         win_seq    [WINDOW_SLOTS];
  bit [63:0]         win_stamp  [WINDOW_SLOTS];
  bit [31:0]         seq_next;
  bit [31:0]         acked_last;
  bit [15:0]         dup_run;
  bit [INFL_W-1:0]   used_cnt;
  bit [31:0]         tmo_limit = TIMEOUT_RESET;

  swst_res_t   window_results_q[$];  // results owed by accepted transactions, oldest first
  swst_cmd_t   cmd_backlog_q[$];     // commands waiting for the driver
  int unsigned send_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned err_cnt       = 0;
  bit [63:0]   clock_us;             // sender's notion of the current time

  initial forever #1 clk_i = ~clk_i;

  // Advance the window mirror by one accepted command and queue the results it owes.
  function automatic void step_window(swst_cmd_t c);
    swst_res_t         outs[$];
    swst_res_t         r;
    logic [31:0]       allow;
    logic [SLOT_W-1:0] idx;
    logic [63:0]       age;
    r = '0;
    case (c.func)
      FUNC_SEND: begin
        // a window below one segment still lets one slot fly
        allow = c.cong_window / MSS_BYTES;
        if (allow == 0) allow = 1;
        idx = seq_next[SLOT_W-1:0];
        if (c.remaining_bytes != 0 && 32'(used_cnt) < allow && !win_used[idx]) begin
          r.kind        = KIND_GRANT;
          r.seq_out     = seq_next;
          r.chunk_len   = (c.remaining_bytes < MSS_BYTES) ? c.remaining_bytes[15:0]
                                                          : 16'(MSS_BYTES);
          r.slot_index  = idx;
          win_used[idx]    = 1'b1;
          win_written[idx] = 1'b1;
          win_seq[idx]     = seq_next;
          win_stamp[idx]   = c.now_time;
          seq_next++;
          used_cnt++;
        end else begin
          // a busy target slot refuses too, so no record is overwritten
          r.kind    = KIND_REFUSE;
          r.seq_out = seq_next;
        end
        r.dup_count = dup_run;
        r.inflight  = used_cnt;
        outs.push_back(r);
      end
      FUNC_ACK: begin
        idx          = c.ack_seq[SLOT_W-1:0];
        r.seq_out    = c.ack_seq;
        r.slot_index = idx;
        if (win_used[idx] && win_seq[idx] == c.ack_seq) begin
          r.kind   = KIND_ACK_TAKEN;
          r.age_us = c.now_time - win_stamp[idx];
          // last_acked starts at zero, so the first ack of sequence zero repeats it
          if (c.ack_seq == acked_last) begin
            if (dup_run != 16'hFFFF) dup_run++;
            r.is_dup = 1'b1;
          end else begin
            dup_run    = '0;
            acked_last = c.ack_seq;
          end
          win_used[idx] = 1'b0;
          used_cnt--;
        end else begin
          r.kind = KIND_ACK_IGNOR;
        end
        r.dup_count = dup_run;
        r.inflight  = used_cnt;
        outs.push_back(r);
      end
      FUNC_SCAN: begin
        // walk slots in order; a backwards clock makes ages wrap and look huge
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
          age = c.now_time - win_stamp[i];
          if (win_used[i] && age > {32'h0, tmo_limit}) begin
            win_used[i] = 1'b0;
            used_cnt--;
            r            = '0;
            r.kind       = KIND_TIMEOUT;
            r.seq_out    = win_seq[i];
            r.slot_index = i[SLOT_W-1:0];
            r.age_us     = age;
            r.dup_count  = dup_run;
            r.inflight   = used_cnt;
            outs.push_back(r);
          end
        end
        if (outs.size() == 0) begin
          r           = '0;
          r.kind      = KIND_NONE_EXP;
          r.dup_count = dup_run;
          r.inflight  = used_cnt;
          outs.push_back(r);
        end
      end
      default: ;  // unused code: no result, no state change
    endcase
    if (outs.size() != 0) begin
      outs[outs.size()-1].last = 1'b1;
      foreach (outs[k]) window_results_q.push_back(outs[k]);
    end
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: present the next backlog entry once the current transaction is taken,
  // or hold start low when the sender idles.
  always @(posedge clk_i) begin
    if (rst_ni && (!start_i || !busy_o)) begin
      if (cmd_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start_i <= 1'b1;
        cmd_i   <= cmd_backlog_q.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check the result of this edge first, then predict the command taken
  // at this edge, so a new prediction can never answer a result in the same step.
  always @(posedge clk_i) begin : watch_ports
    swst_res_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_strobe_o) quiet_cycles <= 0;
      else                                      quiet_cycles <= quiet_cycles + 1;
      if (res_strobe_o) begin
        if (window_results_q.size() == 0) begin
          $display("%0t: result mismatch, expected none, actual kind %0d seq %0h",
                   $time, res_o.kind, res_o.seq_out);
          err_cnt++;
        end else begin
          want = window_results_q.pop_front();
          report_field("kind",       64'(want.kind),       64'(res_o.kind));
          report_field("seq_out",    64'(want.seq_out),    64'(res_o.seq_out));
          report_field("chunk_len",  64'(want.chunk_len),  64'(res_o.chunk_len));
          report_field("slot_index", 64'(want.slot_index), 64'(res_o.slot_index));
          report_field("age_us",     want.age_us,          res_o.age_us);
          report_field("is_dup",     64'(want.is_dup),     64'(res_o.is_dup));
          report_field("dup_count",  64'(want.dup_count),  64'(res_o.dup_count));
          report_field("inflight",   64'(want.inflight),   64'(res_o.inflight));
          report_field("last",       64'(want.last),       64'(res_o.last));
        end
      end
      if (start_i && !busy_o) step_window(cmd_i);
    end
  end

  // Watchdog: stop a run that goes quiet for too long.
  initial begin
    wait (rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("sliding_window_send_tracker_top_tb: errors");
    $finish;
  end

  function automatic swst_cmd_t mk_cmd(logic [1:0] f, logic [63:0] t, logic [31:0] a,
                                       logic [31:0] rem, logic [31:0] win);
    swst_cmd_t c;
    c.func            = f;
    c.now_time        = t;
    c.ack_seq         = a;
    c.remaining_bytes = rem;
    c.cong_window     = win;
    return c;
  endfunction

  // Queue one command at a falling edge. Steer an ack away from a slot that was
  // never written; slot zero is always written by the first grant.
  task automatic push_cmd(swst_cmd_t c);
    do @(negedge clk_i); while (cmd_backlog_q.size() >= BACKLOG_DEPTH);
    if (c.func == FUNC_ACK && !win_written[c.ack_seq[SLOT_W-1:0]])
      c.ack_seq[SLOT_W-1:0] = '0;
    cmd_backlog_q.push_back(c);
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_backlog_q.size() != 0 || start_i || window_results_q.size() != 0);
  endtask

  task automatic set_timeout(logic [31:0] value);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    timeout_we_i    <= 1'b1;
    timeout_wdata_i <= value;
    tmo_limit        = value;
    @(posedge clk_i);
    timeout_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mixed traffic: sends, acks of recent sequences, scans and some noise.
  task automatic run_traffic(int unsigned count);
    swst_cmd_t   c;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick              = $urandom_range(99);
      c.ack_seq         = $urandom;
      c.remaining_bytes = $urandom;
      c.cong_window     = $urandom;
      if (pick < 3) clock_us = {$urandom, $urandom};  // jump anywhere, backwards too
      else          clock_us += $urandom_range(0, (tmo_limit < 4) ? 3 : 1500);
      c.now_time = clock_us;
      if (pick < 48) begin
        c.func = FUNC_SEND;
        case ($urandom_range(9))
          0:       c.remaining_bytes = '0;
          1, 2, 3: c.remaining_bytes = $urandom_range(1, 2 * MSS_BYTES);
          default: ;
        endcase
        case ($urandom_range(9))
          0, 1:          c.cong_window = $urandom_range(0, MSS_BYTES - 1);
          2, 3, 4, 5, 6: c.cong_window = $urandom_range(MSS_BYTES, 40 * MSS_BYTES);
          default: ;
        endcase
      end else if (pick < 82) begin
        c.func = FUNC_ACK;
        if ($urandom_range(9) != 0)
          c.ack_seq = seq_next - 32'd1 - $urandom_range(0, 32'(used_cnt) + 2);
      end else if (pick < 96) begin
        c.func = FUNC_SCAN;
      end else begin
        c.func = FUNC_UNUSED;
        count++;  // ignored commands do not count
      end
      push_cmd(c);
    end
  endtask

  // Clear the window, fill all slots, push one more send onto a busy slot, then
  // expire everything in one scan.
  task automatic run_burst();
    wait_idle();
    clock_us += 64'h2_0000_0000;
    push_cmd(mk_cmd(FUNC_SCAN, clock_us, $urandom, $urandom, $urandom));
    for (int k = 0; k <= WINDOW_SLOTS; k++) begin
      clock_us += 1;
      push_cmd(mk_cmd(FUNC_SEND, clock_us, $urandom, $urandom_range(1, 3000), '1));
    end
    clock_us += 64'h2_0000_0000 + $urandom_range(0, 1000);
    push_cmd(mk_cmd(FUNC_SCAN, clock_us, $urandom, $urandom, $urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset timeout of 1000000 us.
    push_cmd(mk_cmd(FUNC_UNUSED, '1, '1, '1, '1));
    push_cmd(mk_cmd(FUNC_SEND, 64'd0,   32'd0, 32'd0,     '1));            // nothing to send
    push_cmd(mk_cmd(FUNC_SEND, 64'd100, 32'd0, 32'd1,     32'd0));         // small window
    push_cmd(mk_cmd(FUNC_SEND, 64'd101, 32'd0, 32'd5000,  32'd1459));      // window full
    push_cmd(mk_cmd(FUNC_SEND, 64'd102, 32'd0, '1,        '1));
    push_cmd(mk_cmd(FUNC_SEND, 64'd103, 32'd0, 32'd1461,  32'd4380));
    push_cmd(mk_cmd(FUNC_SEND, 64'd104, 32'd0, 32'd1460,  32'd4380));      // at cwnd limit
    wait_idle();
    push_cmd(mk_cmd(FUNC_ACK,  64'd200, 32'd0,  '0, '0));  // first ack of zero is a dup
    push_cmd(mk_cmd(FUNC_ACK,  64'd201, 32'd0,  '0, '0));  // slot already free
    push_cmd(mk_cmd(FUNC_ACK,  64'd202, 32'd65, '0, '0));  // slot holds another seq
    push_cmd(mk_cmd(FUNC_ACK,  '1,      32'd2,  '0, '0));
    push_cmd(mk_cmd(FUNC_ACK,  64'd0,   '1,     '0, '0));
    push_cmd(mk_cmd(FUNC_SCAN, 64'd150, '0,     '0, '0));  // nothing old enough
    push_cmd(mk_cmd(FUNC_SCAN, 64'd0,   '0,     '0, '0));  // clock went backwards
    push_cmd(mk_cmd(FUNC_SEND, '1,      '0,     32'd500, 32'd93440));
    push_cmd(mk_cmd(FUNC_SCAN, 64'd999999,  '0, '0, '0));  // age equals timeout: kept
    push_cmd(mk_cmd(FUNC_SCAN, 64'd1000000, '0, '0, '0));  // one past: expires
    push_cmd(mk_cmd(FUNC_SEND, 64'd5, '0, 32'd1460, 32'd2920));
    push_cmd(mk_cmd(FUNC_SEND, 64'd6, '0, 32'd1459, 32'd2920));
    push_cmd(mk_cmd(FUNC_ACK,  64'd10, 32'd4, '0, '0));
    push_cmd(mk_cmd(FUNC_ACK,  64'd3,  32'd5, '0, '0));    // age wraps

    clock_us = 64'd1000;
    send_idle_pct = 32;
    set_timeout(32'd1);
    run_traffic(50);
    run_burst();
    run_traffic(50);

    send_idle_pct = 74;
    set_timeout(32'hFFFF_FFFF);
    run_traffic(50);
    run_burst();
    run_traffic(50);

    send_idle_pct = 0;
    set_timeout($urandom_range(500, 5000));
    run_traffic(50);
    run_burst();
    run_traffic(50);

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("sliding_window_send_tracker_top_tb: clean");
    end else begin
      $display("sliding_window_send_tracker_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/swst_pkg.sv
hdl/swst_slot_ram.sv
hdl/swst_ctrl.sv
hdl/sliding_window_send_tracker_top.sv
dv/sliding_window_send_tracker_top_tb.sv
